// File: src/assert_macros.svh
// Shared assertion macros. All assertions sample on clk_i and are
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: src/ppi_pkg.sv
package ppi_pkg;

  // Coordinate width, fixed by the payload structs
  localparam int CoordWidth = 16;
  // Command queue depth between front and back
  localparam int QueueDepth = 2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [CoordWidth:0]   delta_t;
  typedef logic        [CoordWidth-1:0] steps_t;

  typedef enum logic {
    OpLoad    = 1'b0,
    OpAdvance = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CmdAdvance = 2'd0,
    CmdOpen    = 2'd1,
    CmdClose   = 2'd2
  } cmd_e;

  typedef struct packed {
    op_e    operation;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   path_start;
  } in_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   segment_last;
  } out_t;

  // Work item handed from front to back
  typedef struct packed {
    cmd_e   op;
    coord_t start_x;
    coord_t start_y;
    delta_t delta_x;
    delta_t delta_y;
    steps_t steps;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Per-axis DDA accumulator: floor of the exact point and remainder in [0, n)
  typedef struct packed {
    coord_t cur;
    steps_t rem;
  } dda_t;

  // cur + rem/n rounded half away from zero
  function automatic coord_t round_point(coord_t cur, steps_t rem, steps_t n);
    logic [CoordWidth:0] two_rem;
    logic [CoordWidth:0] n_ext;
    logic                up;
    two_rem = {rem, 1'b0};
    n_ext   = {1'b0, n};
    up      = (two_rem > n_ext) || ((two_rem == n_ext) && !cur[CoordWidth-1]);
    return cur + coord_t'({{(CoordWidth-1){1'b0}}, up});
  endfunction

  // Add d/n to the accumulator, at most one carry or borrow
  function automatic dda_t dda_step(dda_t acc, delta_t d, steps_t n);
    logic signed [CoordWidth+1:0] s;
    logic signed [CoordWidth+1:0] nn;
    logic signed [CoordWidth+1:0] t;
    dda_t                         res;
    s  = $signed({2'b00, acc.rem}) + $signed({d[CoordWidth], d});
    nn = $signed({2'b00, n});
    res = acc;
    if (s >= nn) begin
      t       = s - nn;
      res.rem = t[CoordWidth-1:0];
      res.cur = acc.cur + coord_t'(1);
    end else if (s < 0) begin
      t       = s + nn;
      res.rem = t[CoordWidth-1:0];
      res.cur = acc.cur - coord_t'(1);
    end else begin
      res.rem = s[CoordWidth-1:0];
    end
    return res;
  endfunction

endpackage

// File: src/ppi_front.sv
module ppi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppi_pkg::in_t  in_data_i,
  input  logic          accept_i,
  output ppi_pkg::cmd_t cmd_o
);
  import ppi_pkg::*;

  coord_t prev_x_q, prev_y_q;
  logic   have_vertex_q;

  delta_t dx, dy, neg_dx, neg_dy;
  steps_t ax, ay, n;

  // Segment setup from the previous vertex
  always_comb begin
    dx     = {in_data_i.vertex_x[CoordWidth-1], in_data_i.vertex_x}
           - {prev_x_q[CoordWidth-1], prev_x_q};
    dy     = {in_data_i.vertex_y[CoordWidth-1], in_data_i.vertex_y}
           - {prev_y_q[CoordWidth-1], prev_y_q};
    neg_dx = -dx;
    neg_dy = -dy;
    ax     = dx[CoordWidth] ? neg_dx[CoordWidth-1:0] : dx[CoordWidth-1:0];
    ay     = dy[CoordWidth] ? neg_dy[CoordWidth-1:0] : dy[CoordWidth-1:0];
    n      = (ax > ay) ? ax : ay;
    if (n == '0) begin
      n = steps_t'(1);
    end
  end

  // Classify the item
  always_comb begin
    cmd_o.start_x = prev_x_q;
    cmd_o.start_y = prev_y_q;
    cmd_o.delta_x = dx;
    cmd_o.delta_y = dy;
    cmd_o.steps   = n;
    if (in_data_i.operation == OpAdvance) begin
      cmd_o.op = CmdAdvance;
    end else if (in_data_i.path_start || !have_vertex_q) begin
      cmd_o.op = CmdClose;
    end else begin
      cmd_o.op = CmdOpen;
    end
  end

  // Previous vertex tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      have_vertex_q <= 1'b0;
    end else if (accept_i && (in_data_i.operation == OpLoad)) begin
      prev_x_q      <= in_data_i.vertex_x;
      prev_y_q      <= in_data_i.vertex_y;
      have_vertex_q <= 1'b1;
    end
  end

endmodule

// File: src/ppi_queue.sv
module ppi_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppi_pkg::cmd_t   push_data_i,
  input  logic            pop_i,
  output ppi_pkg::cmd_t   head_o,
  output ppi_pkg::q_stat_t stat_o
);
  import ppi_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign head_o       = entry_q[rptr_q];
  assign stat_o.full  = (count_q == CntW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: src/ppi_back.sv
module ppi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppi_pkg::cmd_t head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ppi_pkg::out_t out_data_o
);
  import ppi_pkg::*;

  logic   active_q;
  dda_t   acc_x_q, acc_y_q;
  delta_t dx_q, dy_q;
  steps_t n_q, idx_q;
  out_t   out_q;
  logic   out_valid_q;

  logic   last;
  logic   emit;

  // Take the next command when the output register is free or draining
  assign pop_o       = head_valid_i && (!out_valid_q || out_ready_i);
  assign last        = (idx_q == n_q);
  assign emit        = pop_o && (head_i.op == CmdAdvance) && active_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      n_q      <= steps_t'(1);
      idx_q    <= '0;
    end else if (pop_o) begin
      case (head_i.op)
        CmdOpen: begin
          active_q    <= 1'b1;
          acc_x_q.cur <= head_i.start_x;
          acc_x_q.rem <= '0;
          acc_y_q.cur <= head_i.start_y;
          acc_y_q.rem <= '0;
          dx_q        <= head_i.delta_x;
          dy_q        <= head_i.delta_y;
          n_q         <= head_i.steps;
          idx_q       <= '0;
        end
        CmdClose: begin
          active_q <= 1'b0;
        end
        CmdAdvance: begin
          if (active_q) begin
            if (last) begin
              active_q <= 1'b0;
            end else begin
              idx_q   <= idx_q + steps_t'(1);
              acc_x_q <= dda_step(acc_x_q, dx_q, n_q);
              acc_y_q <= dda_step(acc_y_q, dy_q, n_q);
            end
          end
        end
        default: begin
          active_q <= active_q;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.point_x      <= round_point(acc_x_q.cur, acc_x_q.rem, n_q);
      out_q.point_y      <= round_point(acc_y_q.cur, acc_y_q.rem, n_q);
      out_q.segment_last <= last;
    end
  end

endmodule

// File: src/polyline_point_interpolator.sv
// Output: an advance transfer is written into the command queue, and its point is
// registered in the output register when the back end pops it; loads produce no output.
// Throughput: one item per cycle while the output accepts, set by the DDA update in the
// back end; a two-entry command queue absorbs output stalls.
// Reset: asynchronous, active low; clears vertex history, segment state,
// queue pointers and output valid. No clearing pass.
module polyline_point_interpolator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppi_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ppi_pkg::out_t out_data_o
);
  import ppi_pkg::*;

`include "assert_macros.svh"

  cmd_t    front_cmd;
  cmd_t    head;
  q_stat_t q_stat;
  logic    in_xfer;
  logic    pop;
  logic    pop_adv;

  assign in_ready_o = !q_stat.full;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign pop_adv    = pop && (head.op == CmdAdvance);

  // Front end: vertex tracking and command classification
  ppi_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .accept_i  (in_xfer),
    .cmd_o     (front_cmd)
  );

  // Command queue between front and back
  ppi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (front_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // Back end: DDA stepping and output register
  ppi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_stat.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Checks
  `ASSERT_IMPL(a_ready_only_when_room, !in_ready_o, q_stat.full)
  `ASSERT_IMPL(a_queue_state_sane, q_stat.full, !q_stat.empty)
  `ASSERT_IMPL(a_out_from_advance, $rose(out_valid_o), $past(pop_adv))
  `ASSERT_NEXT(a_stall_keeps_queue, out_valid_o && !out_ready_i && !q_stat.empty, !q_stat.empty)

endmodule

// File: sim/tb_top.sv
module tb_top;
  import ppi_pkg::*;

  logic  clk_i;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i   = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  polyline_point_interpolator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Points still owed by the DUT, oldest first
  out_t   exp_points[$];
  int     mismatch_count = 0;
  int     sent_count     = 0;
  // No-idle stretch for both sides
  bit     steady         = 1'b0;
  // Last vertex handed to the DUT, for sizing advance runs
  longint tail_x = 0;
  longint tail_y = 0;

  // Interpolator state mirror
  longint vtx_x = 0, vtx_y = 0;
  bit     have_vtx = 1'b0;
  longint seg_base_x = 0, seg_base_y = 0;
  longint seg_dx = 0, seg_dy = 0;
  longint seg_n = 1, seg_k = 0;
  bit     seg_open = 1'b0;
  longint acc_wx = 0, acc_wy = 0, acc_rx = 0, acc_ry = 0;

  initial begin : clk_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint abs_val(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // base + whole + rem/n, exact halves away from zero
  function automatic longint round_coord(input longint base, input longint whole,
                                         input longint rem, input longint n);
    longint t;
    t = base + whole;
    if (2 * rem > n) return t + 1;
    if (2 * rem == n && t >= 0) return t + 1;
    return t;
  endfunction

  // Add d/n to the accumulator; |d| <= n so at most one carry or borrow
  function automatic void dda_update(inout longint whole, inout longint rem,
                                     input longint d, input longint n);
    rem += d;
    if (rem >= n) begin
      rem -= n;
      whole += 1;
    end else if (rem < 0) begin
      rem += n;
      whole -= 1;
    end
  endfunction

  // Apply one accepted item to the mirror; returns 1 when a point is due
  function automatic bit interp_predict(input in_t item, output out_t pt);
    longint vx, vy, dx, dy, n;
    bit     at_end;
    pt = '0;
    if (item.operation == OpLoad) begin
      vx = longint'($signed(item.vertex_x));
      vy = longint'($signed(item.vertex_y));
      if (item.path_start || !have_vtx) begin
        seg_open = 1'b0;
      end else begin
        dx = vx - vtx_x;
        dy = vy - vtx_y;
        n  = (abs_val(dx) > abs_val(dy)) ? abs_val(dx) : abs_val(dy);
        if (n < 1) n = 1;
        seg_base_x = vtx_x;
        seg_base_y = vtx_y;
        seg_dx     = dx;
        seg_dy     = dy;
        seg_n      = n;
        seg_k      = 0;
        seg_open   = 1'b1;
        acc_wx = 0;
        acc_wy = 0;
        acc_rx = 0;
        acc_ry = 0;
      end
      vtx_x    = vx;
      vtx_y    = vy;
      have_vtx = 1'b1;
      return 1'b0;
    end
    if (!seg_open) return 1'b0;
    pt.point_x = coord_t'(round_coord(seg_base_x, acc_wx, acc_rx, seg_n));
    pt.point_y = coord_t'(round_coord(seg_base_y, acc_wy, acc_ry, seg_n));
    at_end = (seg_k >= seg_n);
    pt.segment_last = at_end;
    if (at_end) begin
      seg_open = 1'b0;
    end else begin
      seg_k++;
      dda_update(acc_wx, acc_rx, seg_dx, seg_n);
      dda_update(acc_wy, acc_ry, seg_dy, seg_n);
    end
    return 1'b1;
  endfunction

  // One input transfer, with a random lead-in gap
  task automatic send_item(input in_t item);
    int   gap;
    out_t pt;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (interp_predict(item, pt)) exp_points.push_back(pt);
    sent_count++;
  endtask

  task automatic put_vertex(input longint x, input longint y, input bit ps);
    in_t item;
    item.operation  = OpLoad;
    item.vertex_x   = coord_t'(x);
    item.vertex_y   = coord_t'(y);
    item.path_start = ps;
    tail_x = x;
    tail_y = y;
    send_item(item);
  endtask

  // Advance transfers; vertex fields and path_start carry junk
  task automatic put_advances(input int count);
    in_t item;
    repeat (count) begin
      item.operation  = OpAdvance;
      item.vertex_x   = coord_t'($urandom);
      item.vertex_y   = coord_t'($urandom);
      item.path_start = 1'($urandom_range(0, 1));
      send_item(item);
    end
  endtask

  // Hold off the sender until every owed point has come out
  task automatic drain_points();
    in_valid_i <= 1'b0;
    while (exp_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // First vertex after reset opens nothing even without path_start
  task automatic test_first_vertex();
    put_vertex(100, -50, 1'b0);
    put_advances(1);
    put_vertex(103, -50, 1'b0);
    put_advances(2);
  endtask

  // Full-range deltas, abandon mid-segment, path start mid-segment
  task automatic test_extreme_segments();
    put_vertex(-32768, -32768, 1'b1);
    put_vertex(32767, 32767, 1'b0);
    put_advances(2);
    put_vertex(32767, -32768, 1'b0);
    put_advances(2);
    put_vertex(0, 0, 1'b1);
    put_advances(1);
  endtask

  // Exact halves both signs, advance past end, zero-length segment
  task automatic test_half_rounding();
    put_vertex(2, 1, 1'b0);
    put_advances(4);
    put_vertex(0, 0, 1'b1);
    put_vertex(-2, -1, 1'b0);
    put_advances(3);
    put_vertex(-2, -1, 1'b0);
    put_advances(2);
  endtask

  // Random polylines, with some junk transfers mixed in
  task automatic test_random_paths(input int target);
    longint nx, ny, dx, dy, n, span;
    int     r, segs, sel, adv;
    in_t    noise;
    while (sent_count < target) begin
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        noise.operation  = op_e'($urandom_range(0, 1));
        noise.vertex_x   = coord_t'($urandom);
        noise.vertex_y   = coord_t'($urandom);
        noise.path_start = 1'($urandom_range(0, 1));
        send_item(noise);
      end else begin
        // path head; now and then continue from the previous tail instead
        if (r >= 15) put_vertex(longint'($signed(coord_t'($urandom))),
                                longint'($signed(coord_t'($urandom))), 1'b1);
        segs = $urandom_range(1, 4);
        repeat (segs) begin
          sel = $urandom_range(0, 19);
          if (sel < 18) begin
            span = (sel < 14) ? 12 : 300;
            dx = longint'($urandom_range(0, 2 * span)) - span;
            dy = longint'($urandom_range(0, 2 * span)) - span;
            nx = tail_x + dx;
            ny = tail_y + dy;
            if (nx > 32767 || nx < -32768) nx = tail_x - dx;
            if (ny > 32767 || ny < -32768) ny = tail_y - dy;
          end else begin
            nx = longint'($signed(coord_t'($urandom)));
            ny = longint'($signed(coord_t'($urandom)));
          end
          n = (abs_val(nx - tail_x) > abs_val(ny - tail_y)) ?
              abs_val(nx - tail_x) : abs_val(ny - tail_y);
          if (n < 1) n = 1;
          put_vertex(nx, ny, 1'b0);
          sel = $urandom_range(0, 9);
          if (sel < 7)      adv = int'(n) + 1;
          else if (sel < 9) adv = int'(n) + 1 + $urandom_range(1, 3);
          else              adv = $urandom_range(0, int'(n));
          if (adv > 40) adv = $urandom_range(1, 12);
          put_advances(adv);
        end
        if ($urandom_range(0, 19) == 0) drain_points();
      end
    end
    steady = 1'b0;
  endtask

  // Output side: random stall before each transfer
  initial begin : sink
    int gap;
    wait (rst_ni);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare each output transfer with the oldest owed point
  always @(posedge clk_i) begin : point_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected point: x=%0d y=%0d last=%0b",
                   $signed(out_data_o.point_x), $signed(out_data_o.point_y),
                   out_data_o.segment_last);
      end else begin
        want = exp_points.pop_front();
        if (out_data_o.point_x !== want.point_x ||
            out_data_o.point_y !== want.point_y ||
            out_data_o.segment_last !== want.segment_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $signed(want.point_x), $signed(want.point_y), want.segment_last,
                     $signed(out_data_o.point_x), $signed(out_data_o.point_y),
                     out_data_o.segment_last);
        end
      end
    end
  end

  initial begin : watchdog
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_seq
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_vertex();
    test_extreme_segments();
    test_half_rounding();
    drain_points();
    test_random_paths(840);
    drain_points();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && exp_points.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: polyline_point_interpolator.f
+incdir+src
src/ppi_pkg.sv
src/ppi_front.sv
src/ppi_queue.sv
src/ppi_back.sv
src/polyline_point_interpolator.sv
sim/tb_top.sv
